/* sv/assert_macros.svh */
// Assertion macros shared by the membership table RTL.
// Each macro wraps one clocked, reset-qualified concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent (ante |=> cons).
`define ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/mcgm_pkg.sv */
// Package for the multicast group membership table.
// Holds sizes, protocol codes and the types shared by the cell row and the top level.
// No dependencies.
package mcgm_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W      = 32;
   localparam int IDENT_W     = 16;
   localparam int COUNT_OUT_W = 5;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 56;

   localparam logic [7:0] MSG_REPORT_V3 = 8'h22;

   localparam logic [7:0] REC_INCLUDE    = 8'd1;
   localparam logic [7:0] REC_EXCLUDE    = 8'd2;
   localparam logic [7:0] REC_LEAVE      = 8'd3;
   localparam logic [7:0] REC_TO_EXCLUDE = 8'd4;

   // identifiers run 1..IDENT_MAX, the counter 0..IDENT_MAX-1
   localparam logic [IDENT_W-1:0] IDENT_MAX = 16'hFFFF;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_MATCH = 3'b010,
      S_APPLY = 3'b100
   } state_type;

   // one table slot as handed between neighbors
   typedef struct packed {
      logic              used;
      logic              excl;
      logic [ADDR_W-1:0] group;
   } entry_type;

   // command broadcast from the controller to every cell
   typedef struct packed {
      logic              compare;
      logic              insert;
      logic              mark;
      logic              remove;
      logic              excl;
      logic [ADDR_W-1:0] addr;
   } cell_cmd_type;

endpackage

/* sv/mcgm_cell.sv */
// One slot of the membership table row.
// Holds a group address and its mode, compares against the broadcast address,
// and shifts down from its upper neighbor when a lower or own entry is removed.
// Depends on mcgm_pkg.
module mcgm_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  mcgm_pkg::cell_cmd_type cmd,
   input  logic                  lower_used,
   input  logic                  shift_in,
   output logic                  shift_out,
   input  mcgm_pkg::entry_type   upper_entry,
   output mcgm_pkg::entry_type   entry,
   output logic                  match
);

   logic                          used_ff, used_in;
   logic                          excl_ff, excl_in;
   logic [mcgm_pkg::ADDR_W-1:0]   group_ff, group_in;
   logic                          match_ff, match_in;
   logic                          take_upper;
   logic                          take_new;

   // removal closes the gap: every slot at or above the hit pulls from above
   assign shift_out  = shift_in | match_ff;
   assign take_upper = cmd.remove & shift_out;
   assign take_new   = cmd.insert & ~used_ff & lower_used;

   always_comb begin
      used_in  = used_ff;
      excl_in  = excl_ff;
      group_in = group_ff;
      match_in = match_ff;
      if (cmd.compare) begin
         match_in = used_ff & (group_ff == cmd.addr);
      end
      if (take_upper) begin
         used_in  = upper_entry.used;
         excl_in  = upper_entry.excl;
         group_in = upper_entry.group;
      end else if (take_new) begin
         used_in  = 1'b1;
         excl_in  = cmd.excl;
         group_in = cmd.addr;
      end else if (cmd.mark && match_ff) begin
         excl_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         used_ff  <= used_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      excl_ff  <= excl_in;
      group_ff <= group_in;
   end

   assign entry.used  = used_ff;
   assign entry.excl  = excl_ff;
   assign entry.group = group_ff;
   assign match       = match_ff;

endmodule

/* sv/multicast_group_membership_table.sv */
// Multicast group membership table: takes one group record per req beat and
// answers with one rsp beat per record.
// req_tdata, low bit first: message_type[7:0], record_type[15:8],
// group_address[47:16]. Only message type 0x22 with record type 1..4 acts:
// include adds an absent group, exclude / change-to-exclude sets exclude mode
// (adding if absent), leave removes a present group and issues a query.
// rsp_tdata, low bit first: query_issued[0], query_group[32:1],
// query_ident[48:33], insert_dropped[49], member_count[54:50], zero pad[55].
// Timing: a taken req beat is captured, compared in parallel in the cell row,
// then applied in the update step, which registers the rsp beat. req_tready
// returns with the update, so no new record is taken until the last one has
// passed that capture / compare / update sequence.
// The result sits in an output register; req_tready comes back while it waits.
// If rsp_tready is low with a result still held, the next record waits in the
// update step until the held beat is taken.
// Reset empties the table (all slots unused), zeroes the count and the query
// identifier counter, and drops any held result.
// Depends on mcgm_pkg, mcgm_cell and assert_macros.svh.
`include "assert_macros.svh"

module multicast_group_membership_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // message_type[7:0], record_type[15:8], group_address[47:16]
   input  logic [mcgm_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // query_issued[0], query_group[32:1], query_ident[48:33],
   // insert_dropped[49], member_count[54:50], pad[55]
   output logic [mcgm_pkg::RSP_DATA_W-1:0]   rsp_tdata
);

   localparam int D = mcgm_pkg::TABLE_DEPTH;

   mcgm_pkg::state_type                state_ff, state_in;
   logic [7:0]                         msg_ff, msg_in;
   logic [7:0]                         rec_ff, rec_in;
   logic [mcgm_pkg::ADDR_W-1:0]        addr_ff, addr_in;
   logic [mcgm_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [mcgm_pkg::IDENT_W-1:0]       qcnt_ff, qcnt_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [mcgm_pkg::RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;

   mcgm_pkg::cell_cmd_type             cmd;
   mcgm_pkg::entry_type                entries [D];
   logic [D-1:0]                       match_vec;
   logic [D-1:0]                       used_vec;
   logic [D:0]                         shift_chain;

   logic                               req_fire;
   logic                               apply_go;
   logic                               rec_ok;
   logic                               hit;
   logic                               full;
   logic                               do_insert, do_mark, do_remove, ins_excl;
   logic                               issued, dropped;
   logic [mcgm_pkg::IDENT_W-1:0]       ident;

   assign req_tready = (state_ff == mcgm_pkg::S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign apply_go   = (state_ff == mcgm_pkg::S_APPLY) & (~rsp_valid_ff | rsp_tready);

   assign hit    = |match_vec;
   assign full   = (count_ff == mcgm_pkg::CNT_W'(D));
   assign rec_ok = (msg_ff == mcgm_pkg::MSG_REPORT_V3) &&
                   (rec_ff inside {mcgm_pkg::REC_INCLUDE, mcgm_pkg::REC_EXCLUDE,
                                   mcgm_pkg::REC_LEAVE, mcgm_pkg::REC_TO_EXCLUDE});

   always_comb begin
      do_insert = 1'b0;
      do_mark   = 1'b0;
      do_remove = 1'b0;
      ins_excl  = 1'b0;
      dropped   = 1'b0;
      if (rec_ok) begin
         case (rec_ff)
            mcgm_pkg::REC_INCLUDE: begin
               do_insert = ~hit & ~full;
               dropped   = ~hit & full;
            end
            mcgm_pkg::REC_LEAVE: begin
               do_remove = hit;
            end
            default: begin
               ins_excl  = 1'b1;
               do_mark   = hit;
               do_insert = ~hit & ~full;
               dropped   = ~hit & full;
            end
         endcase
      end
   end

   assign issued = do_remove;
   assign ident  = qcnt_ff + mcgm_pkg::IDENT_W'(1);

   always_comb begin
      cmd.compare = (state_ff == mcgm_pkg::S_MATCH);
      cmd.insert  = apply_go & do_insert;
      cmd.mark    = apply_go & do_mark;
      cmd.remove  = apply_go & do_remove;
      cmd.excl    = ins_excl;
      cmd.addr    = addr_ff;
   end

   assign shift_chain[0] = 1'b0;

   for (genvar i = 0; i < D; i++) begin : g_cell
      mcgm_pkg::entry_type upper;
      logic                lower_used;
      if (i == D - 1) begin : g_top
         assign upper = '0;
      end else begin : g_mid
         assign upper = entries[i+1];
      end
      if (i == 0) begin : g_bottom
         assign lower_used = 1'b1;
      end else begin : g_above
         assign lower_used = entries[i-1].used;
      end
      mcgm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .lower_used  (lower_used),
         .shift_in    (shift_chain[i]),
         .shift_out   (shift_chain[i+1]),
         .upper_entry (upper),
         .entry       (entries[i]),
         .match       (match_vec[i])
      );
      assign used_vec[i] = entries[i].used;
   end

   always_comb begin
      state_in     = state_ff;
      msg_in       = msg_ff;
      rec_in       = rec_ff;
      addr_in      = addr_ff;
      count_in     = count_ff;
      qcnt_in      = qcnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         mcgm_pkg::S_IDLE: begin
            if (req_fire) begin
               msg_in   = req_tdata[7:0];
               rec_in   = req_tdata[15:8];
               addr_in  = req_tdata[47:16];
               state_in = mcgm_pkg::S_MATCH;
            end
         end
         mcgm_pkg::S_MATCH: begin
            state_in = mcgm_pkg::S_APPLY;
         end
         mcgm_pkg::S_APPLY: begin
            if (apply_go) begin
               if (do_insert) begin
                  count_in = count_ff + mcgm_pkg::CNT_W'(1);
               end else if (do_remove) begin
                  count_in = count_ff - mcgm_pkg::CNT_W'(1);
               end
               if (issued) begin
                  qcnt_in = (qcnt_ff == mcgm_pkg::IDENT_MAX - mcgm_pkg::IDENT_W'(1)) ?
                            '0 : ident;
               end
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0,
                               mcgm_pkg::COUNT_OUT_W'(count_in),
                               dropped,
                               issued ? ident : mcgm_pkg::IDENT_W'(0),
                               issued ? addr_ff : mcgm_pkg::ADDR_W'(0),
                               issued};
               state_in     = mcgm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mcgm_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcgm_pkg::S_IDLE;
         count_ff     <= '0;
         qcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         qcnt_ff      <= qcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      msg_ff      <= msg_in;
      rec_ff      <= rec_in;
      addr_ff     <= addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // table never overfills, and the occupied slots always match the count
   `ASSERT_CLK(a_count_bound, count_ff <= mcgm_pkg::CNT_W'(D), "member count above table depth")
   `ASSERT_CLK(a_used_count, $countones(used_vec) == int'(count_ff), "used slots differ from count")
   // addresses are unique, so at most one slot can hit
   `ASSERT_CLK(a_single_hit, $onehot0(match_vec), "more than one slot matched")
   `ASSERT_NEXT(a_accept_match, req_fire, state_ff == mcgm_pkg::S_MATCH,
                "accept not followed by compare")
   `ASSERT_CLK(a_ident_nonzero, !(rsp_valid_ff && rsp_data_ff[0]) || (rsp_data_ff[48:33] != '0),
               "issued query with zero identifier")

endmodule
